// File: rtl/core/dih_pkg.sv
// dih_pkg: types and constants shared by the dihedral angle pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package dih_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int FRAC_BITS    = 16;
	localparam int VEC_BITS     = 20;
	localparam int SQRT_PAD     = 20;
	localparam int ANGLE_FRAC   = 24;
	localparam int CORDIC_STEPS = 25;
	localparam int MAG_BITS     = 30;
	localparam int PI_Z         = 52707179;

	localparam int ANGLE_W = FRAC_BITS + 3;
	localparam int VW      = VEC_BITS + 1;           // fitted vector component
	localparam int PW      = 2 * VW;                 // component product
	localparam int DW      = PW + 1;                 // dot products, cross product
	localparam int NW      = PW;                     // squared bond length
	localparam int TW      = DW + VW;                // triple product
	localparam int RAD_W   = NW + SQRT_PAD;          // sqrt radicand
	localparam int ROOT_W  = RAD_W / 2;
	localparam int XW      = DW + NW + SQRT_PAD / 2 + 3;
	localparam int ZW      = ANGLE_FRAC + 3;         // CORDIC angle accumulator

	localparam logic [ANGLE_FRAC-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] p0_x;
		logic signed [COORD_WIDTH-1:0] p0_y;
		logic signed [COORD_WIDTH-1:0] p0_z;
		logic signed [COORD_WIDTH-1:0] p1_x;
		logic signed [COORD_WIDTH-1:0] p1_y;
		logic signed [COORD_WIDTH-1:0] p1_z;
		logic signed [COORD_WIDTH-1:0] p2_x;
		logic signed [COORD_WIDTH-1:0] p2_y;
		logic signed [COORD_WIDTH-1:0] p2_z;
		logic signed [COORD_WIDTH-1:0] p3_x;
		logic signed [COORD_WIDTH-1:0] p3_y;
		logic signed [COORD_WIDTH-1:0] p3_z;
	} dih_in_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic                      degenerate;
	} dih_out_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
	} vec_t;

	typedef struct packed {
		vec_t b0;
		vec_t b1;
		vec_t b2;
		logic deg;
	} vecs_t;

	typedef struct packed {
		logic signed [DW-1:0] d01;
		logic signed [DW-1:0] d12;
		logic signed [DW-1:0] d02;
		logic        [NW-1:0] n;
		logic signed [TW-1:0] t;
		logic                 deg;
	} dots_t;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zero;
		logic deg;
	} quad_t;

endpackage

`default_nettype wire

// File: rtl/core/dihedral_angle_four_points_top.sv
// Dihedral (torsion) angle of four 3D points, fully pipelined: a new point
// quadruple is taken every cycle while the output is not stalled. Data pass
// through vector fit, dot products, square root, X/Y forming and normalization,
// CORDIC and an output register; the square root bit stages and CORDIC
// rotations set the pipeline depth. The whole pipeline holds
// while a result waits at the output; in_ready is high whenever the output
// register is empty or being taken. The angle is Q3.16 radians in [-pi, pi];
// when p1 equals p2 the result has degenerate set and angle 0.
// Depends on dih_pkg, dih_fit, dih_dots, dih_isqrt, dih_xy, dih_cordic.
`default_nettype none

module dihedral_angle_four_points_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dih_pkg::dih_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dih_pkg::dih_out_t out_data
);
	import dih_pkg::*;

	localparam int SH  = ANGLE_FRAC - FRAC_BITS;
	localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;
	localparam int LIM = (PI_Z + RND) >> SH;
	localparam int RW  = ZW + 1;

	logic                 en;
	logic                 fit_valid, dots_valid, sq_valid, xy_valid, cor_valid;
	vecs_t                vecs;
	dots_t                dots, sq_dots;
	logic [$bits(dots_t)-1:0] sq_side;
	logic [ROOT_W-1:0]    root;
	logic [MAG_BITS-1:0]  x_mag, y_mag;
	quad_t                quad, cor_quad;
	logic [$bits(quad_t)-1:0] cor_side;
	logic signed [ZW-1:0] z;
	logic signed [RW-1:0] r_c, rr_c, rnd_c;
	logic signed [ANGLE_W-1:0] angle_c;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	dih_fit u_fit (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .in_data(in_data),
		.out_valid(fit_valid), .out_vecs(vecs)
	);

	dih_dots u_dots (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(fit_valid), .vecs(vecs),
		.out_valid(dots_valid), .dots(dots)
	);

	dih_isqrt #(.RAD_W(RAD_W), .SIDE_W($bits(dots_t))) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(dots_valid), .rad({dots.n, {SQRT_PAD{1'b0}}}), .in_side(dots),
		.out_valid(sq_valid), .root(root), .out_side(sq_side)
	);

	assign sq_dots = dots_t'(sq_side);

	dih_xy u_xy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sq_valid), .dots(sq_dots), .root(root),
		.out_valid(xy_valid), .x_mag(x_mag), .y_mag(y_mag), .quad(quad)
	);

	dih_cordic #(.SIDE_W($bits(quad_t))) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(xy_valid), .x_in(x_mag), .y_in(y_mag), .in_side(quad),
		.out_valid(cor_valid), .z_out(z), .out_side(cor_side)
	);

	assign cor_quad = quad_t'(cor_side);

	// restore quadrant, round half up, clamp to +-pi; zero when degenerate or X and Y are both zero
	always_comb begin
		r_c   = cor_quad.xneg ? (RW'(PI_Z) - RW'(z)) : RW'(z);
		rr_c  = cor_quad.yneg ? -r_c : r_c;
		rnd_c = (rr_c + RW'(RND)) >>> SH;
		if (rnd_c > RW'(LIM))
			angle_c = ANGLE_W'(LIM);
		else if (rnd_c < -RW'(LIM))
			angle_c = ANGLE_W'(-LIM);
		else
			angle_c = ANGLE_W'(rnd_c);
		if (cor_quad.deg || cor_quad.zero)
			angle_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= cor_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.angle      <= angle_c;
			out_data.degenerate <= cor_quad.deg;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dih_fit.sv
// dih_fit: bond vectors from the four points and power-of-two fit to 21 bits.
// Three stages. Depends on dih_pkg.
`default_nettype none

module dih_fit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  dih_pkg::dih_in_t in_data,
	output logic            out_valid,
	output dih_pkg::vecs_t  out_vecs
);
	import dih_pkg::*;

	localparam int BW = COORD_WIDTH + 1;
	localparam int LW = $clog2(BW + 1);

	logic signed [COORD_WIDTH-1:0] pt [4][3];
	logic signed [BW-1:0]          b_s1 [3][3];
	logic signed [BW-1:0]          b_s2 [3][3];
	logic [LW-1:0]                 len_s2 [3];
	logic [LW-1:0]                 len_c [3];
	logic signed [VW-1:0]          fit_c [3][3];
	logic                          deg_s1, deg_s2;
	logic                          v_s1, v_s2;

	function automatic logic [BW-1:0] mag_f(input logic signed [BW-1:0] v);
		return v[BW-1] ? BW'(-v) : BW'(v);
	endfunction

	function automatic logic [LW-1:0] bitlen_f(input logic [BW-1:0] v);
		logic [LW-1:0] n;
		n = '0;
		for (int k = 0; k < BW; k++) begin
			if (v[k]) n = LW'(k + 1);
		end
		return n;
	endfunction

	always_comb begin
		pt[0][0] = in_data.p0_x; pt[0][1] = in_data.p0_y; pt[0][2] = in_data.p0_z;
		pt[1][0] = in_data.p1_x; pt[1][1] = in_data.p1_y; pt[1][2] = in_data.p1_z;
		pt[2][0] = in_data.p2_x; pt[2][1] = in_data.p2_y; pt[2][2] = in_data.p2_z;
		pt[3][0] = in_data.p3_x; pt[3][1] = in_data.p3_y; pt[3][2] = in_data.p3_z;
	end

	// bit length of the largest magnitude equals that of the OR of all three
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			len_c[j] = bitlen_f(mag_f(b_s1[j][0]) | mag_f(b_s1[j][1]) | mag_f(b_s1[j][2]));
		end
	end

	// b0, b2 only shrink; b1 also grows so its top bit lands just below VEC_BITS
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) begin
				if (len_s2[j] > VEC_BITS)
					fit_c[j][i] = VW'(b_s2[j][i] >>> (len_s2[j] - VEC_BITS));
				else if (j == 1 && len_s2[j] != '0 && len_s2[j] < VEC_BITS)
					fit_c[j][i] = VW'(b_s2[j][i] <<< (VEC_BITS - len_s2[j]));
				else
					fit_c[j][i] = VW'(b_s2[j][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				b_s1[0][i] <= BW'(pt[0][i]) - BW'(pt[1][i]);
				b_s1[1][i] <= BW'(pt[2][i]) - BW'(pt[1][i]);
				b_s1[2][i] <= BW'(pt[3][i]) - BW'(pt[2][i]);
			end
			deg_s1 <= (pt[1][0] == pt[2][0]) && (pt[1][1] == pt[2][1]) &&
				(pt[1][2] == pt[2][2]);
			b_s2   <= b_s1;
			len_s2 <= len_c;
			deg_s2 <= deg_s1;
			out_vecs.b0.x <= fit_c[0][0];
			out_vecs.b0.y <= fit_c[0][1];
			out_vecs.b0.z <= fit_c[0][2];
			out_vecs.b1.x <= fit_c[1][0];
			out_vecs.b1.y <= fit_c[1][1];
			out_vecs.b1.z <= fit_c[1][2];
			out_vecs.b2.x <= fit_c[2][0];
			out_vecs.b2.y <= fit_c[2][1];
			out_vecs.b2.z <= fit_c[2][2];
			out_vecs.deg  <= deg_s2;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dih_dots.sv
// dih_dots: dot products, squared bond length and triple product b1.(b0 x b2).
// Four stages. Depends on dih_pkg.
`default_nettype none

module dih_dots (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  dih_pkg::vecs_t vecs,
	output logic           out_valid,
	output dih_pkg::dots_t dots
);
	import dih_pkg::*;

	localparam int N1 [3] = '{1, 2, 0};
	localparam int N2 [3] = '{2, 0, 1};

	logic signed [VW-1:0] b0_c [3], b1_c [3], b2_c [3];

	logic signed [PW-1:0] p01_s4 [3], p21_s4 [3], p02_s4 [3], pnn_s4 [3];
	logic signed [PW-1:0] cx_s4 [3], cy_s4 [3];
	logic signed [VW-1:0] b1_s4 [3], b1_s5 [3];
	logic signed [DW-1:0] d01_s5, d12_s5, d02_s5, d01_s6, d12_s6, d02_s6;
	logic [NW-1:0]        n_s5, n_s6;
	logic signed [DW-1:0] c_s5 [3];
	logic signed [TW-1:0] tp_s6 [3];
	logic                 deg_s4, deg_s5, deg_s6;
	logic                 v_s4, v_s5, v_s6;

	always_comb begin
		b0_c[0] = vecs.b0.x; b0_c[1] = vecs.b0.y; b0_c[2] = vecs.b0.z;
		b1_c[0] = vecs.b1.x; b1_c[1] = vecs.b1.y; b1_c[2] = vecs.b1.z;
		b2_c[0] = vecs.b2.x; b2_c[1] = vecs.b2.y; b2_c[2] = vecs.b2.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s4      <= in_valid;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p01_s4[i] <= b0_c[i] * b1_c[i];
				p21_s4[i] <= b2_c[i] * b1_c[i];
				p02_s4[i] <= b0_c[i] * b2_c[i];
				pnn_s4[i] <= b1_c[i] * b1_c[i];
				cx_s4[i]  <= b0_c[N1[i]] * b2_c[N2[i]];
				cy_s4[i]  <= b0_c[N2[i]] * b2_c[N1[i]];
			end
			b1_s4  <= b1_c;
			deg_s4 <= vecs.deg;

			d01_s5 <= DW'(p01_s4[0]) + DW'(p01_s4[1]) + DW'(p01_s4[2]);
			d12_s5 <= DW'(p21_s4[0]) + DW'(p21_s4[1]) + DW'(p21_s4[2]);
			d02_s5 <= DW'(p02_s4[0]) + DW'(p02_s4[1]) + DW'(p02_s4[2]);
			n_s5   <= NW'(DW'(pnn_s4[0]) + DW'(pnn_s4[1]) + DW'(pnn_s4[2]));
			for (int i = 0; i < 3; i++) begin
				c_s5[i] <= DW'(cx_s4[i]) - DW'(cy_s4[i]);
			end
			b1_s5  <= b1_s4;
			deg_s5 <= deg_s4;

			for (int i = 0; i < 3; i++) begin
				tp_s6[i] <= b1_s5[i] * c_s5[i];
			end
			d01_s6 <= d01_s5;
			d12_s6 <= d12_s5;
			d02_s6 <= d02_s5;
			n_s6   <= n_s5;
			deg_s6 <= deg_s5;

			dots.t   <= tp_s6[0] + tp_s6[1] + tp_s6[2];
			dots.d01 <= d01_s6;
			dots.d12 <= d12_s6;
			dots.d02 <= d02_s6;
			dots.n   <= n_s6;
			dots.deg <= deg_s6;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dih_isqrt.sv
// dih_isqrt: pipelined integer square root, one result bit per stage,
// with a side word carried alongside. Depends on dih_pkg.
`default_nettype none

module dih_isqrt #(
	parameter int RAD_W  = 62,
	parameter int SIDE_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     rad,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic [RAD_W/2-1:0]   root,
	output logic [SIDE_W-1:0]    out_side
);
	import dih_pkg::*;

	localparam int RT_W = RAD_W / 2;
	localparam int AW   = RAD_W + 1;

	logic [AW-1:0]     rem_s  [1:RT_W-1];
	logic [AW-1:0]     root_s [1:RT_W];
	logic [SIDE_W-1:0] side_s [1:RT_W];
	logic              vld_s  [1:RT_W];
	logic [AW-1:0]     rem_c  [RT_W];
	logic [AW-1:0]     root_c [RT_W];

	function automatic logic [2*AW-1:0] step_f(input logic [AW-1:0] r_in,
		input logic [AW-1:0] q_in, input int k);
		logic [AW-1:0] bitv, trial;
		bitv  = AW'(1) << (2 * (RT_W - 1 - k));
		trial = q_in + bitv;
		if (r_in >= trial)
			return {r_in - trial, (q_in >> 1) + bitv};
		else
			return {r_in, q_in >> 1};
	endfunction

	always_comb begin
		{rem_c[0], root_c[0]} = step_f(AW'(rad), '0, 0);
		for (int k = 1; k < RT_W; k++) begin
			{rem_c[k], root_c[k]} = step_f(rem_s[k], root_s[k], k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= RT_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 1; k < RT_W; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= in_side;
			for (int k = 1; k < RT_W; k++) side_s[k+1] <= side_s[k];
			for (int k = 0; k < RT_W - 1; k++) rem_s[k+1] <= rem_c[k];
			for (int k = 0; k < RT_W; k++) root_s[k+1] <= root_c[k];
		end
	end

	assign out_valid = vld_s[RT_W];
	assign root      = root_s[RT_W][RT_W-1:0];
	assign out_side  = side_s[RT_W];

endmodule

`default_nettype wire

// File: rtl/core/dih_xy.sv
// dih_xy: forms X and Y from the dot products and the root, takes signs and
// magnitudes and normalizes both to MAG_BITS. Six stages. Depends on dih_pkg.
`default_nettype none

module dih_xy (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  dih_pkg::dots_t              dots,
	input  logic [dih_pkg::ROOT_W-1:0]  root,
	output logic                        out_valid,
	output logic [dih_pkg::MAG_BITS-1:0] x_mag,
	output logic [dih_pkg::MAG_BITS-1:0] y_mag,
	output dih_pkg::quad_t              quad
);
	import dih_pkg::*;

	localparam int SPL = 22;              // split point for partial products
	localparam int HW  = DW - SPL;
	localparam int LOW = SPL + 1;
	localparam int PPW = 2 * LOW;
	localparam int TH  = TW / 2;
	localparam int YPW = TH + ROOT_W + 3;
	localparam int LW  = $clog2(XW + 1);

	logic signed [HW-1:0]     d02_h, d01_h, d12_h, n_h;
	logic signed [LOW-1:0]    d02_l, d01_l, d12_l, n_l;
	logic signed [TH-1:0]     t_h;
	logic signed [TH:0]       t_l;
	logic signed [ROOT_W:0]   s_c;

	logic signed [PPW-1:0] a_hh_s1, a_hl_s1, a_lh_s1, a_ll_s1;
	logic signed [PPW-1:0] b_hh_s1, b_hl_s1, b_lh_s1, b_ll_s1;
	logic signed [YPW-1:0] y_h_s1, y_l_s1;
	logic signed [XW-1:0]  p1_s2, p2_s2, y_s2, x_s3, y_s3;
	logic [XW-1:0]         xabs_c, yabs_c;
	logic [XW-1:0]         xa_s4, ya_s4, xa_s5, ya_s5;
	logic [LW-1:0]         len_s5;
	logic [LW-1:0]         len_c;
	logic                  deg_s1, deg_s2, deg_s3;
	dih_pkg::quad_t        quad_s4, quad_s5;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;

	always_comb begin
		d02_h = $signed(dots.d02[DW-1:SPL]);
		d01_h = $signed(dots.d01[DW-1:SPL]);
		d12_h = $signed(dots.d12[DW-1:SPL]);
		n_h   = $signed({1'b0, dots.n[NW-1:SPL]});
		d02_l = $signed({1'b0, dots.d02[SPL-1:0]});
		d01_l = $signed({1'b0, dots.d01[SPL-1:0]});
		d12_l = $signed({1'b0, dots.d12[SPL-1:0]});
		n_l   = $signed({1'b0, dots.n[SPL-1:0]});
		t_h   = $signed(dots.t[TW-1:TH]);
		t_l   = $signed({1'b0, dots.t[TH-1:0]});
		s_c   = $signed({1'b0, root});
	end

	always_comb begin
		xabs_c = x_s3[XW-1] ? XW'(-x_s3) : XW'(x_s3);
		yabs_c = y_s3[XW-1] ? XW'(-y_s3) : XW'(y_s3);
		len_c  = '0;
		for (int k = 0; k < XW; k++) begin
			if (xa_s4[k] | ya_s4[k]) len_c = LW'(k + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_hh_s1 <= d02_h * n_h;
			a_hl_s1 <= d02_h * n_l;
			a_lh_s1 <= d02_l * n_h;
			a_ll_s1 <= d02_l * n_l;
			b_hh_s1 <= d01_h * d12_h;
			b_hl_s1 <= d01_h * d12_l;
			b_lh_s1 <= d01_l * d12_h;
			b_ll_s1 <= d01_l * d12_l;
			y_h_s1  <= t_h * s_c;
			y_l_s1  <= t_l * s_c;
			deg_s1  <= dots.deg;

			p1_s2  <= (XW'(a_hh_s1) <<< (2 * SPL)) +
				((XW'(a_hl_s1) + XW'(a_lh_s1)) <<< SPL) + XW'(a_ll_s1);
			p2_s2  <= (XW'(b_hh_s1) <<< (2 * SPL)) +
				((XW'(b_hl_s1) + XW'(b_lh_s1)) <<< SPL) + XW'(b_ll_s1);
			y_s2   <= (XW'(y_h_s1) <<< TH) + XW'(y_l_s1);
			deg_s2 <= deg_s1;

			x_s3   <= (p1_s2 - p2_s2) <<< (SQRT_PAD / 2);
			y_s3   <= y_s2;
			deg_s3 <= deg_s2;

			xa_s4        <= xabs_c;
			ya_s4        <= yabs_c;
			quad_s4.xneg <= x_s3[XW-1];
			quad_s4.yneg <= y_s3[XW-1];
			quad_s4.zero <= (xabs_c | yabs_c) == '0;
			quad_s4.deg  <= deg_s3;

			xa_s5   <= xa_s4;
			ya_s5   <= ya_s4;
			len_s5  <= len_c;
			quad_s5 <= quad_s4;

			// right shift truncates, left shift fills zeros
			if (len_s5 > MAG_BITS) begin
				x_mag <= MAG_BITS'(xa_s5 >> (len_s5 - MAG_BITS));
				y_mag <= MAG_BITS'(ya_s5 >> (len_s5 - MAG_BITS));
			end else begin
				x_mag <= MAG_BITS'(xa_s5 << (MAG_BITS - len_s5));
				y_mag <= MAG_BITS'(ya_s5 << (MAG_BITS - len_s5));
			end
			quad <= quad_s5;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dih_cordic.sv
// dih_cordic: vectoring-mode CORDIC, one rotation per stage, first-quadrant
// angle in Q.ANGLE_FRAC with a side word carried alongside. Depends on dih_pkg.
`default_nettype none

module dih_cordic #(
	parameter int SIDE_W = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [dih_pkg::MAG_BITS-1:0]  x_in,
	input  logic [dih_pkg::MAG_BITS-1:0]  y_in,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	output logic signed [dih_pkg::ZW-1:0] z_out,
	output logic [SIDE_W-1:0]             out_side
);
	import dih_pkg::*;

	localparam int CW = MAG_BITS + 3;
	localparam int NS = CORDIC_STEPS;
	localparam int SW = 2 * CW + ZW;

	logic signed [CW-1:0] x_s [1:NS];
	logic signed [CW-1:0] y_s [1:NS];
	logic signed [ZW-1:0] z_s [1:NS];
	logic [SIDE_W-1:0]    side_s [1:NS];
	logic                 vld_s [1:NS];
	logic signed [CW-1:0] x_c [NS];
	logic signed [CW-1:0] y_c [NS];
	logic signed [ZW-1:0] z_c [NS];

	function automatic logic [SW-1:0] step_f(input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input logic signed [ZW-1:0] z, input int k);
		logic signed [CW-1:0] xs, ys;
		logic signed [ZW-1:0] a;
		xs = x >>> k;
		ys = y >>> k;
		a  = $signed(ZW'(ATAN_TAB[k]));
		if (!y[CW-1])
			return {x + ys, y - xs, z + a};
		else
			return {x - ys, y + xs, z - a};
	endfunction

	always_comb begin
		{x_c[0], y_c[0], z_c[0]} = step_f($signed(CW'(x_in)), $signed(CW'(y_in)), '0, 0);
		for (int k = 1; k < NS; k++) begin
			{x_c[k], y_c[k], z_c[k]} = step_f(x_s[k], y_s[k], z_s[k], k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 1; k < NS; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= in_side;
			for (int k = 1; k < NS; k++) side_s[k+1] <= side_s[k];
			for (int k = 0; k < NS; k++) begin
				x_s[k+1] <= x_c[k];
				y_s[k+1] <= y_c[k];
				z_s[k+1] <= z_c[k];
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign z_out     = z_s[NS];
	assign out_side  = side_s[NS];

endmodule

`default_nettype wire

// File: rtl/core/dih_chk.sv
// dih_chk: port-level checks on the dihedral angle block, bound to the top.
// Depends on dih_pkg and dihedral_angle_four_points_top.
`default_nettype none

module dih_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input dih_pkg::dih_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input dih_pkg::dih_out_t out_data
);
	import dih_pkg::*;

	localparam int SH  = ANGLE_FRAC - FRAC_BITS;
	localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;
	localparam logic signed [ANGLE_W-1:0] LIM = ANGLE_W'((PI_Z + RND) >> SH);

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.angle == '0)
		else $error("degenerate result with nonzero angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.angle <= LIM) && (out_data.angle >= -LIM))
		else $error("angle outside +-pi");

	// pipeline only holds off input while a result is stuck at the output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

endmodule

bind dihedral_angle_four_points_top dih_chk u_dih_chk (.*);

`default_nettype wire
